### hw/rtl/tapm_pkg.sv
package tapm_pkg;

    localparam int unsigned C_COORD_BITS = 16;
    localparam int unsigned C_SENS_FRAC  = 12;
    localparam logic [C_COORD_BITS-1:0] C_HALF = 16'h8000;
    localparam logic [C_COORD_BITS-1:0] C_MAX  = 16'hFFFF;

    localparam logic [15:0] C_RST_CENTER = 16'd32768;
    localparam logic [15:0] C_RST_SIZE   = 16'd65535;
    localparam logic [15:0] C_RST_WIDTH  = 16'd1920;
    localparam logic [15:0] C_RST_HEIGHT = 16'd1080;
    localparam logic [15:0] C_RST_SENS   = 16'd4096;

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_SIZE_X   = 3'd2,
        CFG_SIZE_Y   = 3'd3,
        CFG_WIDTH    = 3'd4,
        CFG_HEIGHT   = 3'd5,
        CFG_SENS     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] point_x;
        logic [15:0] point_y;
    } t_point_in;

    typedef struct packed {
        logic [15:0] mapped_x;
        logic [15:0] mapped_y;
    } t_point_out;

    typedef struct packed {
        logic        wide;
        logic        neg;
        logic [16:0] other;
    } t_aspect_side;

endpackage

### hw/rtl/tapm_div_cell.sv
module tapm_div_cell
    import tapm_pkg::*;
#(
    parameter int unsigned D = 16,
    parameter int unsigned Q = 17,
    parameter int unsigned S = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [D-1:0] i_rem,
    input  logic [Q-1:0] i_num,
    input  logic [D-1:0] i_div,
    input  logic [S-1:0] i_side,
    output logic         o_valid,
    output logic [D-1:0] o_rem,
    output logic [Q-1:0] o_num,
    output logic [S-1:0] o_side
);

    logic [D:0]   w_trial;
    logic         w_ge;
    logic [D-1:0] n_rem;
    logic [Q-1:0] n_num;
    logic         r_valid;
    logic [D-1:0] r_rem;
    logic [Q-1:0] r_num;
    logic [S-1:0] r_side;

    always_comb begin
        w_trial = {i_rem, i_num[Q-1]};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? D'(w_trial - {1'b0, i_div}) : w_trial[D-1:0];
        n_num   = {i_num[Q-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_side  = r_side;

endmodule

### hw/rtl/tapm_div_chain.sv
module tapm_div_chain
    import tapm_pkg::*;
#(
    parameter int unsigned D = 16,
    parameter int unsigned Q = 17,
    parameter int unsigned S = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [D-1:0] i_rem,
    input  logic [Q-1:0] i_num,
    input  logic [D-1:0] i_div,
    input  logic [S-1:0] i_side,
    output logic         o_valid,
    output logic [Q-1:0] o_quo,
    output logic [S-1:0] o_side
);

    logic         w_valid [Q+1];
    logic [D-1:0] w_rem   [Q+1];
    logic [Q-1:0] w_num   [Q+1];
    logic [S-1:0] w_side  [Q+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_rem;
    assign w_num[0]   = i_num;
    assign w_side[0]  = i_side;

    for (genvar g = 0; g < Q; g++) begin : g_cell
        tapm_div_cell #(.D(D), .Q(Q), .S(S)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_num   (w_num[g]),
            .i_div   (i_div),
            .i_side  (w_side[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_num   (w_num[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign o_valid = w_valid[Q];
    assign o_quo   = w_num[Q];
    assign o_side  = w_side[Q];

endmodule

### hw/rtl/tablet_area_point_mapper.sv
// Channel  | Signals                             | Word
// input    | i_in_valid, o_in_stall, i_in_data   | t_point_in
// output   | o_out_valid, i_out_stall, o_out_data| t_point_out
// config   | i_cfg_we, i_cfg_idx, i_cfg_data     | 16-bit register
// One word per cycle unless stalled; stages: entry register, 17 remap divider
// cells, aspect multiply, 16 aspect divider cells, gain multiply, output.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// A stalled output word freezes the whole pipeline and stalls the input.
module tablet_area_point_mapper
    import tapm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_point_in  i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_point_out o_out_data,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    function automatic logic [32:0] f_remap_pre(input logic [15:0] p, input logic [15:0] c,
                                                input logic [15:0] s);
        logic signed [18:0] lo2;
        logic signed [18:0] hi2;
        logic signed [18:0] p2;
        logic [16:0]        diff;
        lo2 = $signed({2'b00, c, 1'b0}) - $signed({3'b000, s});
        hi2 = $signed({2'b00, c, 1'b0}) + $signed({3'b000, s});
        p2  = $signed({2'b00, p, 1'b0});
        if (p2 < lo2) p2 = lo2;
        if (p2 > hi2) p2 = hi2;
        diff = 17'(p2 - lo2);
        return {(s == 16'd0), diff[16:2], diff[1:0], 15'd0};
    endfunction

    function automatic logic [15:0] f_finish(input logic [31:0] prod, input logic neg);
        logic [19:0] r;
        logic [20:0] sum;
        r   = prod[31:12];
        sum = {5'd0, C_HALF} + {1'b0, r};
        if (neg) begin
            return (r > {4'd0, C_HALF}) ? 16'd0 : 16'({4'd0, C_HALF} - r);
        end
        return (sum > {5'd0, C_MAX}) ? C_MAX : sum[15:0];
    endfunction

    logic [15:0] r_cx, r_cy, r_sx, r_sy, r_w, r_h, r_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= C_RST_CENTER;
            r_cy <= C_RST_CENTER;
            r_sx <= C_RST_SIZE;
            r_sy <= C_RST_SIZE;
            r_w  <= C_RST_WIDTH;
            r_h  <= C_RST_HEIGHT;
            r_g  <= C_RST_SENS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_cx <= i_cfg_data;
                CFG_CENTER_Y: r_cy <= i_cfg_data;
                CFG_SIZE_X:   r_sx <= i_cfg_data;
                CFG_SIZE_Y:   r_sy <= i_cfg_data;
                CFG_WIDTH:    r_w  <= i_cfg_data;
                CFG_HEIGHT:   r_h  <= i_cfg_data;
                CFG_SENS:     r_g  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_valid;
    t_point_out r_out;

    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    // entry stage
    logic [32:0] w_pre_x, w_pre_y;
    logic        r_a_valid, r_a_zx, r_a_zy;
    logic [15:0] r_a_remx, r_a_remy;
    logic [16:0] r_a_numx, r_a_numy;

    assign w_pre_x = f_remap_pre(i_in_data.point_x, r_cx, r_sx);
    assign w_pre_y = f_remap_pre(i_in_data.point_y, r_cy, r_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_zx   <= w_pre_x[32];
            r_a_remx <= {1'b0, w_pre_x[31:17]};
            r_a_numx <= w_pre_x[16:0];
            r_a_zy   <= w_pre_y[32];
            r_a_remy <= {1'b0, w_pre_y[31:17]};
            r_a_numy <= w_pre_y[16:0];
        end
    end

    logic        w_x_valid;
    logic [16:0] w_qx, w_qy;
    logic        w_zx, w_zy;

    tapm_div_chain #(.D(16), .Q(17), .S(1)) u_remap_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_a_valid), .i_rem (r_a_remx), .i_num (r_a_numx),
        .i_div (r_sx), .i_side (r_a_zx),
        .o_valid (w_x_valid), .o_quo (w_qx), .o_side (w_zx)
    );

    tapm_div_chain #(.D(16), .Q(17), .S(1)) u_remap_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_a_valid), .i_rem (r_a_remy), .i_num (r_a_numy),
        .i_div (r_sy), .i_side (r_a_zy),
        .o_valid (), .o_quo (w_qy), .o_side (w_zy)
    );

    // aspect multiply stage
    logic [16:0] w_u, w_v, w_a;
    logic        w_wide, w_tall, w_neg;
    logic [15:0] w_mag, w_m, w_q;
    logic        r_b_valid;
    logic [31:0] r_b_prod;
    t_aspect_side r_b_side, w_c_side;

    always_comb begin
        w_u    = w_zx ? {1'b0, C_HALF} : w_qx;
        w_v    = w_zy ? {1'b0, C_HALF} : w_qy;
        w_wide = (r_w > r_h);
        w_tall = !w_wide && (r_h != 16'd0);
        w_a    = w_wide ? w_u : w_v;
        w_neg  = (w_a < {1'b0, C_HALF});
        w_mag  = w_neg ? 16'({1'b0, C_HALF} - w_a) : 16'(w_a - {1'b0, C_HALF});
        w_m    = w_wide ? r_h : (w_tall ? r_w : 16'd1);
        w_q    = w_wide ? r_w : (w_tall ? r_h : 16'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= w_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_prod       <= w_mag * w_m;
            r_b_side.wide  <= w_wide;
            r_b_side.neg   <= w_neg;
            r_b_side.other <= w_wide ? w_v : w_u;
        end
    end

    logic        w_c_valid;
    logic [15:0] w_r;

    tapm_div_chain #(.D(16), .Q(16), .S($bits(t_aspect_side))) u_aspect (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (r_b_valid), .i_rem (r_b_prod[31:16]), .i_num (r_b_prod[15:0]),
        .i_div (w_q), .i_side (r_b_side),
        .o_valid (w_c_valid), .o_quo (w_r), .o_side (w_c_side)
    );

    // gain multiply stage
    logic        w_oneg;
    logic [15:0] w_omag, w_magx, w_magy;
    logic        w_sx, w_sy;
    logic        r_c_valid, r_c_sx, r_c_sy;
    logic [31:0] r_c_px, r_c_py;

    always_comb begin
        w_oneg = (w_c_side.other < {1'b0, C_HALF});
        w_omag = w_oneg ? 16'({1'b0, C_HALF} - w_c_side.other)
                        : 16'(w_c_side.other - {1'b0, C_HALF});
        w_magx = w_c_side.wide ? w_r : w_omag;
        w_sx   = w_c_side.wide ? w_c_side.neg : w_oneg;
        w_magy = w_c_side.wide ? w_omag : w_r;
        w_sy   = w_c_side.wide ? w_oneg : w_c_side.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= w_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_px <= w_magx * r_g;
            r_c_py <= w_magy * r_g;
            r_c_sx <= w_sx;
            r_c_sy <= w_sy;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.mapped_x <= f_finish(r_c_px, r_c_sx);
            r_out.mapped_y <= f_finish(r_c_py, r_c_sy);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/tapm_checker.sv
module tapm_checker
    import tapm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_point_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output blocked");

    a_free_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind tablet_area_point_mapper tapm_checker u_tapm_checker (.*);

### tb/sv/tb_top.sv
module tb_top;
    import tapm_pkg::*;

    localparam int LATENCY   = 37;
    localparam int WDOG_MAX  = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_point_in   i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_point_out  o_out_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    logic [15:0] cfg_regs [0:6];
    t_point_out  expected_points [$];
    int          error_count;
    int          idle_cycles;
    bit          quiet_mode;
    int          send_gap;
    int          sink_gap;

    tablet_area_point_mapper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint remap_to_unit(longint p, longint c, longint s);
        longint lo2;
        longint hi2;
        longint p2;
        if (s == 0) begin
            return 32768;
        end
        lo2 = 2 * c - s;
        hi2 = 2 * c + s;
        p2  = 2 * p;
        if (p2 < lo2) begin
            p2 = lo2;
        end
        if (p2 > hi2) begin
            p2 = hi2;
        end
        return ((p2 - lo2) <<< 15) / s;
    endfunction

    function automatic longint scale_offset(longint d, longint m, longint q);
        longint mag;
        mag = (d < 0) ? -d : d;
        mag = (mag * m) / q;
        return (d < 0) ? -mag : mag;
    endfunction

    function automatic logic [15:0] saturate_coord(longint v);
        if (v < 0) begin
            return 16'd0;
        end
        if (v > 65535) begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    function automatic t_point_out map_point(t_point_in pt);
        longint u;
        longint v;
        longint w;
        longint h;
        t_point_out res;
        u = remap_to_unit(pt.point_x, cfg_regs[CFG_CENTER_X], cfg_regs[CFG_SIZE_X]);
        v = remap_to_unit(pt.point_y, cfg_regs[CFG_CENTER_Y], cfg_regs[CFG_SIZE_Y]);
        w = cfg_regs[CFG_WIDTH];
        h = cfg_regs[CFG_HEIGHT];
        if (w > h) begin
            u = 32768 + scale_offset(u - 32768, h, w);
        end else if (h != 0) begin
            v = 32768 + scale_offset(v - 32768, w, h);
        end
        u = 32768 + scale_offset(u - 32768, cfg_regs[CFG_SENS], 4096);
        v = 32768 + scale_offset(v - 32768, cfg_regs[CFG_SENS], 4096);
        res.mapped_x = saturate_coord(u);
        res.mapped_y = saturate_coord(v);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        cfg_regs[idx] = value;
        @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_point(logic [15:0] px, logic [15:0] py);
        t_point_in pt;
        i_cfg_we <= 1'b0;
        if (!quiet_mode && send_gap == 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 9);
        end
        while (send_gap > 0) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            send_gap--;
        end
        pt.point_x = px;
        pt.point_y = py;
        i_in_valid <= 1'b1;
        i_in_data  <= pt;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        expected_points.push_back(map_point(pt));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected word", o_out_data.mapped_x, 16'd0);
                end else begin
                    if (o_out_data.mapped_x != expected_points[0].mapped_x) begin
                        report_mismatch("mapped_x", o_out_data.mapped_x,
                                        expected_points[0].mapped_x);
                    end
                    if (o_out_data.mapped_y != expected_points[0].mapped_y) begin
                        report_mismatch("mapped_y", o_out_data.mapped_y,
                                        expected_points[0].mapped_y);
                    end
                    void'(expected_points.pop_front());
                end
            end
            if (sink_gap > 0) begin
                i_out_stall <= 1'b1;
                sink_gap <= sink_gap - 1;
            end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
                i_out_stall <= 1'b1;
                sink_gap <= $urandom_range(0, 8);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WDOG_MAX) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic test_reset_defaults();
        send_point(16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h8000, 16'h8000);
        send_point(16'h5555, 16'hAAAA);
        drain_pipeline();
    endtask

    task automatic test_corner_cases();
        write_reg(CFG_SIZE_X, 16'd0);
        write_reg(CFG_SIZE_Y, 16'd1);
        write_reg(CFG_CENTER_Y, 16'hFFFF);
        send_point(16'h1234, 16'hFFFF);
        send_point(16'hFFFF, 16'h0000);
        write_reg(CFG_SIZE_X, 16'd20000);
        write_reg(CFG_CENTER_X, 16'd0);
        write_reg(CFG_SIZE_Y, 16'hFFFF);
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_HEIGHT, 16'd100);
        send_point(16'h0000, 16'h0100);
        send_point(16'h2000, 16'hFFFF);
        write_reg(CFG_WIDTH, 16'd100);
        write_reg(CFG_HEIGHT, 16'd0);
        send_point(16'h0001, 16'h7FFF);
        write_reg(CFG_WIDTH, 16'd0);
        send_point(16'hFFFF, 16'h0000);
        write_reg(CFG_WIDTH, 16'd1);
        write_reg(CFG_HEIGHT, 16'hFFFF);
        write_reg(CFG_SENS, 16'hFFFF);
        send_point(16'h0000, 16'hFFFF);
        send_point(16'h8001, 16'h7FFF);
        write_reg(CFG_SENS, 16'd0);
        send_point(16'h0000, 16'hFFFF);
        write_reg(CFG_WIDTH, 16'hFFFF);
        write_reg(CFG_HEIGHT, 16'd1);
        write_reg(CFG_SENS, 16'd8192);
        send_point(16'hFFFF, 16'h0000);
        send_point(16'h0000, 16'hFFFF);
        drain_pipeline();
    endtask

    task automatic test_random_points(int count, bit calm);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                drain_pipeline();
                write_reg(CFG_CENTER_X, 16'($urandom_range(0, 65535)));
                write_reg(CFG_CENTER_Y, 16'($urandom_range(0, 65535)));
                write_reg(CFG_SIZE_X, ($urandom_range(0, 15) == 0) ? 16'd0
                                      : 16'($urandom_range(1, 65535)));
                write_reg(CFG_SIZE_Y, ($urandom_range(0, 15) == 0) ? 16'd0
                                      : 16'($urandom_range(1, 65535)));
                write_reg(CFG_WIDTH, ($urandom_range(0, 15) == 0) ? 16'd0
                                     : 16'($urandom_range(1, 65535)));
                write_reg(CFG_HEIGHT, ($urandom_range(0, 15) == 0) ? 16'd0
                                      : 16'($urandom_range(1, 65535)));
                write_reg(CFG_SENS, 16'($urandom_range(0, 65535)));
            end
            quiet_mode = calm;
            send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
        drain_pipeline();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_CENTER_X;
        i_cfg_data  <= '0;
        error_count = 0;
        idle_cycles = 0;
        quiet_mode  = 1'b0;
        send_gap    = 0;
        sink_gap    = 0;
        cfg_regs[CFG_CENTER_X] = C_RST_CENTER;
        cfg_regs[CFG_CENTER_Y] = C_RST_CENTER;
        cfg_regs[CFG_SIZE_X]   = C_RST_SIZE;
        cfg_regs[CFG_SIZE_Y]   = C_RST_SIZE;
        cfg_regs[CFG_WIDTH]    = C_RST_WIDTH;
        cfg_regs[CFG_HEIGHT]   = C_RST_HEIGHT;
        cfg_regs[CFG_SENS]     = C_RST_SENS;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_corner_cases();
        test_random_points(1400, 1'b0);
        test_random_points(300, 1'b1);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/tapm_pkg.sv
hw/rtl/tapm_div_cell.sv
hw/rtl/tapm_div_chain.sv
hw/rtl/tablet_area_point_mapper.sv
hw/rtl/tapm_checker.sv
tb/sv/tb_top.sv
